FILE: design/fst_pkg.sv
package fst_pkg;

   // Fixed widths of the result word fields.
   localparam int NUM_W  = 5;
   localparam int TIME_W = 16;
   localparam int RES_W  = 21;
   localparam int SUM_W  = 25;

   // Controller states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_CALC,
      ST_OUT
   } fst_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // store the accepted input word
      logic pass_init;  // restart the minimum search over the job memory
      logic scan;       // advance the minimum search
      logic calc;       // compute the start time of the chosen job
      logic emit;       // load the result register and update the running state
   } fst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // every stored job has been compared
      logic rsp_free;   // the result register can take a new word
      logic last_job;   // the job being emitted is the last of the batch
   } fst_status_type;

endpackage

FILE: design/fst_ctrl.sv
module fst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_batch_end,
   output logic                   req_stall,
   input  fst_pkg::fst_status_type status,
   output fst_pkg::fst_cmd_type    cmd
);

   fst_pkg::fst_state_type state_ff;
   fst_pkg::fst_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fst_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         fst_pkg::ST_LOAD: begin
            // Jobs are taken one per cycle until the word marked as batch end.
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_batch_end) begin
                  cmd.pass_init = 1'b1;
                  state_in      = fst_pkg::ST_SCAN;
               end
            end
         end
         fst_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = fst_pkg::ST_CALC;
            end
         end
         fst_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = fst_pkg::ST_OUT;
         end
         fst_pkg::ST_OUT: begin
            // Wait for room for the result, then search for the next job or reload.
            if (status.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.pass_init = 1'b1;
               state_in      = status.last_job ? fst_pkg::ST_LOAD : fst_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = fst_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

FILE: design/fst_datapath.sv
module fst_datapath #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fst_pkg::fst_cmd_type          cmd,
   output fst_pkg::fst_status_type       status,
   input  logic [fst_pkg::TIME_W-1:0]   req_arrival_time,
   input  logic [fst_pkg::TIME_W-1:0]   req_burst_time,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fst_pkg::NUM_W-1:0]    rsp_job_number,
   output logic [fst_pkg::TIME_W-1:0]   rsp_job_arrival,
   output logic [fst_pkg::TIME_W-1:0]   rsp_job_burst,
   output logic [fst_pkg::RES_W-1:0]    rsp_completion_time,
   output logic [fst_pkg::RES_W-1:0]    rsp_turnaround_time,
   output logic [fst_pkg::RES_W-1:0]    rsp_waiting_time,
   output logic [fst_pkg::SUM_W-1:0]    rsp_total_turnaround,
   output logic [fst_pkg::SUM_W-1:0]    rsp_total_waiting,
   output logic                         rsp_final_job
);

   localparam int SB       = (TIME_BITS < fst_pkg::TIME_W) ? TIME_BITS : fst_pkg::TIME_W;
   localparam int IDX_BITS = $clog2(MAX_JOBS);
   localparam int CNT_BITS = $clog2(MAX_JOBS + 1);
   localparam int CT_BITS  = SB + CNT_BITS;
   localparam int CALC_W   = (CT_BITS > fst_pkg::SUM_W) ? CT_BITS : fst_pkg::SUM_W;
   localparam int NUMX_W   = (CNT_BITS > fst_pkg::NUM_W) ? CNT_BITS : fst_pkg::NUM_W;

   // Job memory: arrival in the upper half, burst in the lower half.
   logic [2*SB-1:0]          job_mem_ff [MAX_JOBS];

   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [CNT_BITS-1:0]      addr_ff, addr_in;
   logic [CNT_BITS-1:0]      emitted_ff, emitted_in;
   logic                     rd_vld_ff;
   logic [2*SB-1:0]          rd_word_ff;
   logic [IDX_BITS-1:0]      rd_idx_ff;
   logic                     best_vld_ff, best_vld_in;
   logic [SB-1:0]            best_arr_ff, best_bur_ff;
   logic [IDX_BITS-1:0]      best_idx_ff;
   logic                     prev_vld_ff, prev_vld_in;
   logic [SB-1:0]            prev_arr_ff;
   logic [IDX_BITS-1:0]      prev_idx_ff;
   logic [CT_BITS-1:0]       start_ff, start_in;
   logic [CT_BITS-1:0]       last_comp_ff, last_comp_in;
   logic [fst_pkg::SUM_W-1:0] sum_tat_ff, sum_tat_in;
   logic [fst_pkg::SUM_W-1:0] sum_wt_ff, sum_wt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     rd_en;
   logic                     full;
   logic                     take;
   logic [SB-1:0]            rd_arr;
   logic [SB-1:0]            rd_bur;
   logic [CT_BITS-1:0]       best_arr_ext;
   logic [CALC_W-1:0]        ct_calc, wt_calc, tat_calc;
   logic [NUMX_W-1:0]        num_calc;

   // Memory write on load and registered read during the scan.
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         job_mem_ff[count_ff[IDX_BITS-1:0]] <= {req_arrival_time[SB-1:0],
                                               req_burst_time[SB-1:0]};
      end
      if (rd_en) begin
         rd_word_ff <= job_mem_ff[addr_ff[IDX_BITS-1:0]];
         rd_idx_ff  <= addr_ff[IDX_BITS-1:0];
      end
   end

   // Scan control and the running schedule state.
   always_comb begin
      full   = (count_ff == CNT_BITS'(MAX_JOBS));
      rd_en  = cmd.scan && (addr_ff < count_ff);
      rd_arr = rd_word_ff[2*SB-1:SB];
      rd_bur = rd_word_ff[SB-1:0];

      status.scan_done = (addr_ff == count_ff) && !rd_vld_ff;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
      status.last_job  = ((emitted_ff + CNT_BITS'(1)) == count_ff);

      // The next job is the smallest (arrival, number) key above the one sent last.
      take = rd_vld_ff
             && (!prev_vld_ff || ({rd_arr, rd_idx_ff} > {prev_arr_ff, prev_idx_ff}))
             && (!best_vld_ff || ({rd_arr, rd_idx_ff} < {best_arr_ff, best_idx_ff}));

      addr_in = addr_ff;
      if (cmd.pass_init) begin
         addr_in = '0;
      end else if (rd_en) begin
         addr_in = addr_ff + CNT_BITS'(1);
      end

      best_vld_in = best_vld_ff;
      if (cmd.pass_init) begin
         best_vld_in = 1'b0;
      end else if (take) begin
         best_vld_in = 1'b1;
      end

      // The job starts at the later of its arrival and the previous completion.
      best_arr_ext = CT_BITS'(best_arr_ff);
      start_in     = (last_comp_ff > best_arr_ext) ? last_comp_ff : best_arr_ext;

      ct_calc  = CALC_W'(start_ff) + CALC_W'(best_bur_ff);
      wt_calc  = CALC_W'(start_ff) - CALC_W'(best_arr_ff);
      tat_calc = wt_calc + CALC_W'(best_bur_ff);
      num_calc = NUMX_W'(best_idx_ff) + NUMX_W'(1);

      count_in     = count_ff;
      emitted_in   = emitted_ff;
      prev_vld_in  = prev_vld_ff;
      last_comp_in = last_comp_ff;
      sum_tat_in   = sum_tat_ff;
      sum_wt_in    = sum_wt_ff;
      if (cmd.load && !full) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (cmd.emit) begin
         if (status.last_job) begin
            // End of batch: ready for the next one.
            count_in     = '0;
            emitted_in   = '0;
            prev_vld_in  = 1'b0;
            last_comp_in = '0;
            sum_tat_in   = '0;
            sum_wt_in    = '0;
         end else begin
            emitted_in   = emitted_ff + CNT_BITS'(1);
            prev_vld_in  = 1'b1;
            last_comp_in = ct_calc[CT_BITS-1:0];
            sum_tat_in   = sum_tat_ff + tat_calc[fst_pkg::SUM_W-1:0];
            sum_wt_in    = sum_wt_ff + wt_calc[fst_pkg::SUM_W-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         addr_ff      <= '0;
         emitted_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         prev_vld_ff  <= 1'b0;
         last_comp_ff <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         emitted_ff   <= emitted_in;
         rd_vld_ff    <= rd_en;
         best_vld_ff  <= best_vld_in;
         prev_vld_ff  <= prev_vld_in;
         last_comp_ff <= last_comp_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: search candidates, start time and the result word.
   always_ff @(posedge clock) begin
      if (take) begin
         best_arr_ff <= rd_arr;
         best_bur_ff <= rd_bur;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.calc) begin
         start_ff <= start_in;
      end
      if (cmd.emit) begin
         prev_arr_ff          <= best_arr_ff;
         prev_idx_ff          <= best_idx_ff;
         rsp_job_number       <= num_calc[fst_pkg::NUM_W-1:0];
         rsp_job_arrival      <= fst_pkg::TIME_W'(best_arr_ff);
         rsp_job_burst        <= fst_pkg::TIME_W'(best_bur_ff);
         rsp_completion_time  <= ct_calc[fst_pkg::RES_W-1:0];
         rsp_turnaround_time  <= tat_calc[fst_pkg::RES_W-1:0];
         rsp_waiting_time     <= wt_calc[fst_pkg::RES_W-1:0];
         rsp_total_turnaround <= sum_tat_ff + tat_calc[fst_pkg::SUM_W-1:0];
         rsp_total_waiting    <= sum_wt_ff + wt_calc[fst_pkg::SUM_W-1:0];
         rsp_final_job        <= status.last_job;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_JOBS))
      else $error("job count exceeds the store size");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten before it was taken");

   a_calc_has_job: assert property (@(posedge clock) disable iff (reset)
      cmd.calc |-> best_vld_ff)
      else $error("scan finished without choosing a job");

   a_scan_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (emitted_ff < count_ff))
      else $error("scan started with every job already sent");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_job) |=> (count_ff == '0 && !prev_vld_ff))
      else $error("batch state not cleared after the last result");
`endif

endmodule

FILE: design/fcfs_schedule_timing.sv
// Jobs are loaded at one word per cycle while the block is in its load phase.
// After the batch-end word, each result is found by a linear scan of the job
// memory through its single read port, which picks the next job in (arrival,
// number) order; the CALC state then registers its start time and the OUT state
// computes and registers the result word. Synchronous active-high reset clears
// all control state; the job memory holds undefined data until written.
module fcfs_schedule_timing #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [fst_pkg::TIME_W-1:0] req_arrival_time,
   input  logic [fst_pkg::TIME_W-1:0] req_burst_time,
   input  logic                       req_batch_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [fst_pkg::NUM_W-1:0]  rsp_job_number,
   output logic [fst_pkg::TIME_W-1:0] rsp_job_arrival,
   output logic [fst_pkg::TIME_W-1:0] rsp_job_burst,
   output logic [fst_pkg::RES_W-1:0]  rsp_completion_time,
   output logic [fst_pkg::RES_W-1:0]  rsp_turnaround_time,
   output logic [fst_pkg::RES_W-1:0]  rsp_waiting_time,
   output logic [fst_pkg::SUM_W-1:0]  rsp_total_turnaround,
   output logic [fst_pkg::SUM_W-1:0]  rsp_total_waiting,
   output logic                       rsp_final_job
);

   fst_pkg::fst_cmd_type    cmd;
   fst_pkg::fst_status_type status;

   // Sequencer for load, scan, compute and output.
   fst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_batch_end (req_batch_end),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Job memory, minimum search and schedule arithmetic.
   fst_datapath #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_arrival_time     (req_arrival_time),
      .req_burst_time       (req_burst_time),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_job_number       (rsp_job_number),
      .rsp_job_arrival      (rsp_job_arrival),
      .rsp_job_burst        (rsp_job_burst),
      .rsp_completion_time  (rsp_completion_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_waiting_time     (rsp_waiting_time),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_final_job        (rsp_final_job)
   );

endmodule

FILE: sim/tb_fcfs_schedule_timing.sv
module tb_fcfs_schedule_timing;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_W  = fst_pkg::NUM_W;
   localparam int TIME_W = fst_pkg::TIME_W;
   localparam int RES_W  = fst_pkg::RES_W;
   localparam int SUM_W  = fst_pkg::SUM_W;

   localparam int JOB_SLOTS   = 16;
   localparam int TIME_MAX    = 65535;
   localparam int RANDOM_JOBS = 335;
   localparam int HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT = 250000;

   // One scheduled job as it leaves the block.
   typedef struct {
      logic [NUM_W-1:0]  number;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [RES_W-1:0]  completion;
      logic [RES_W-1:0]  turnaround;
      logic [RES_W-1:0]  waiting;
      logic [SUM_W-1:0]  sum_turn;
      logic [SUM_W-1:0]  sum_wait;
      logic              last;
   } sched_result_type;

   // Keeps its own copy of the job store and predicts the schedule of each batch.
   class fcfs_scoreboard;
      logic [TIME_W-1:0] arr_slot[JOB_SLOTS];
      logic [TIME_W-1:0] bur_slot[JOB_SLOTS];
      logic [NUM_W-1:0]  num_slot[JOB_SLOTS];
      int unsigned       stored;
      sched_result_type  schedule_q[$];
      int unsigned       mismatches;
      int unsigned       results_seen;

      function new();
         stored       = 0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      // Notes an accepted job word; a batch-end word releases the whole schedule.
      function void note_job(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur, logic ends);
         logic [TIME_W-1:0] a_key, b_key;
         logic [NUM_W-1:0]  n_key;
         int                j;
         longint unsigned   prev_done, begin_at, done, tat, wt, tot_tat, tot_wt;
         sched_result_type  r;

         // A full store drops the job but still honors its batch-end mark.
         if (stored < JOB_SLOTS) begin
            arr_slot[stored] = arr;
            bur_slot[stored] = bur;
            num_slot[stored] = NUM_W'(stored + 1);
            stored++;
         end
         if (!ends) return;

         // Stable insertion sort on arrival keeps ties in job-number order.
         for (int i = 1; i < stored; i++) begin
            a_key = arr_slot[i];
            b_key = bur_slot[i];
            n_key = num_slot[i];
            j = i;
            while (j > 0 && arr_slot[j-1] > a_key) begin
               arr_slot[j] = arr_slot[j-1];
               bur_slot[j] = bur_slot[j-1];
               num_slot[j] = num_slot[j-1];
               j--;
            end
            arr_slot[j] = a_key;
            bur_slot[j] = b_key;
            num_slot[j] = n_key;
         end

         // Serve in order, idling until each job has arrived.
         prev_done = 0;
         tot_tat   = 0;
         tot_wt    = 0;
         for (int k = 0; k < stored; k++) begin
            begin_at  = (prev_done > arr_slot[k]) ? prev_done : arr_slot[k];
            done      = begin_at + bur_slot[k];
            tat       = done - arr_slot[k];
            wt        = tat - bur_slot[k];
            prev_done = done;
            tot_tat  += tat;
            tot_wt   += wt;
            r.number     = num_slot[k];
            r.arrival    = arr_slot[k];
            r.burst      = bur_slot[k];
            r.completion = done[RES_W-1:0];
            r.turnaround = tat[RES_W-1:0];
            r.waiting    = wt[RES_W-1:0];
            r.sum_turn   = tot_tat[SUM_W-1:0];
            r.sum_wait   = tot_wt[SUM_W-1:0];
            r.last       = (k == stored - 1);
            schedule_q.push_back(r);
         end
         stored = 0;
      endfunction

      function void compare_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            flag($sformatf("%s expected %0d got %0d", field, want, got));
         end
      endfunction

      // Checks a result word against the oldest predicted one.
      function void check_result(sched_result_type got);
         sched_result_type want;
         results_seen++;
         if (schedule_q.size() == 0) begin
            flag($sformatf("unexpected result word for job %0d", got.number));
            return;
         end
         want = schedule_q.pop_front();
         compare_field("job_number", want.number, got.number);
         compare_field("job_arrival", want.arrival, got.arrival);
         compare_field("job_burst", want.burst, got.burst);
         compare_field("completion_time", want.completion, got.completion);
         compare_field("turnaround_time", want.turnaround, got.turnaround);
         compare_field("waiting_time", want.waiting, got.waiting);
         compare_field("total_turnaround", want.sum_turn, got.sum_turn);
         compare_field("total_waiting", want.sum_wait, got.sum_wait);
         compare_field("final_job", want.last, got.last);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [TIME_W-1:0] req_arrival_time = '0;
   logic [TIME_W-1:0] req_burst_time = '0;
   logic              req_batch_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [NUM_W-1:0]  rsp_job_number;
   logic [TIME_W-1:0] rsp_job_arrival;
   logic [TIME_W-1:0] rsp_job_burst;
   logic [RES_W-1:0]  rsp_completion_time;
   logic [RES_W-1:0]  rsp_turnaround_time;
   logic [RES_W-1:0]  rsp_waiting_time;
   logic [SUM_W-1:0]  rsp_total_turnaround;
   logic [SUM_W-1:0]  rsp_total_waiting;
   logic              rsp_final_job;

   fcfs_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int unsigned    random_words = 0;
   int unsigned    gap_pending = 0;
   int unsigned    burst_left = 0;
   bit             no_idle = 1'b0;

   fcfs_schedule_timing #(
      .MAX_JOBS (JOB_SLOTS),
      .TIME_BITS(TIME_W)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .req_batch_end       (req_batch_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_job_number      (rsp_job_number),
      .rsp_job_arrival     (rsp_job_arrival),
      .rsp_job_burst       (rsp_job_burst),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_total_turnaround(rsp_total_turnaround),
      .rsp_total_waiting   (rsp_total_waiting),
      .rsp_final_job       (rsp_final_job)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up if the run stalls far past its slowest correct length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Watch both handshakes at the clock edge and feed the scoreboard.
   always @(posedge clock) begin : watch
      sched_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_job(req_arrival_time, req_burst_time, req_batch_end);
         end
         if (rsp_valid && !rsp_stall) begin
            got.number     = rsp_job_number;
            got.arrival    = rsp_job_arrival;
            got.burst      = rsp_job_burst;
            got.completion = rsp_completion_time;
            got.turnaround = rsp_turnaround_time;
            got.waiting    = rsp_waiting_time;
            got.sum_turn   = rsp_total_turnaround;
            got.sum_wait   = rsp_total_waiting;
            got.last       = rsp_final_job;
            sb.check_result(got);
         end
      end
   end

   // Mostly uniform times, with the extremes drawn often.
   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return TIME_W'(TIME_MAX);
      return TIME_W'($urandom_range(0, TIME_MAX));
   endfunction

   // Offers one job word and waits until the block takes it.
   task automatic offer_word(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur,
                             input logic ends);
      if (gap_pending != 0) begin
         req_valid <= 1'b0;
         repeat (gap_pending) @(posedge clock);
         gap_pending = 0;
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arr;
      req_burst_time   <= bur;
      req_batch_end    <= ends;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // Bursts of random length separated by random gaps.
      if (!no_idle) begin
         if (burst_left == 0) begin
            gap_pending = $urandom_range(1, 8);
            burst_left  = $urandom_range(1, 10);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Sends one batch of n jobs; narrow arrivals force ties in the sort.
   task automatic send_batch(input int n, input bit tie_heavy);
      logic [TIME_W-1:0] arr;
      for (int i = 0; i < n; i++) begin
         arr = tie_heavy ? TIME_W'($urandom_range(0, 7)) : pick_time();
         offer_word(arr, pick_time(), i == n - 1);
         random_words++;
      end
   endtask

   // Receiver stall patterns, with one long hold-off that fills the block.
   initial begin : receiver
      int unsigned mode, stretch, pat;
      bit          held_off;
      held_off = 1'b0;
      pat      = 0;
      while (reset) @(posedge clock);
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         repeat (stretch) begin
            @(posedge clock);
            pat++;
            if (!held_off && sb.results_seen >= 40) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  0: begin
                     rsp_stall <= 1'b0;
                  end
                  1: begin
                     rsp_stall <= ($urandom_range(0, 3) == 0);
                  end
                  2: begin
                     rsp_stall <= ((pat % 5) < 2);
                  end
                  default: begin
                     rsp_stall <= ($urandom_range(0, 1) == 0);
                  end
               endcase
            end
         end
      end
   end

   // Main sequence: reset, directed batches, random batches, then drain.
   initial begin
      int unsigned roll, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A single job with zero arrival and zero burst.
      offer_word('0, '0, 1'b1);

      // Extremes and equal arrivals, loaded out of order.
      offer_word(16'hFFFF, 16'hFFFF, 1'b0);
      offer_word(16'hFFFF, 16'h0000, 1'b0);
      offer_word(16'h0000, 16'hFFFF, 1'b0);
      offer_word(16'h5555, 16'hAAAA, 1'b0);
      offer_word(16'hAAAA, 16'h5555, 1'b1);

      // An idle gap between two jobs, given in reverse arrival order.
      offer_word(16'd1000, 16'd5, 1'b0);
      offer_word(16'd100, 16'd10, 1'b1);

      // Overfill the store: the last word is dropped but still ends the batch.
      for (int i = 0; i < JOB_SLOTS + 1; i++) begin
         offer_word(pick_time(), pick_time(), i == JOB_SLOTS);
      end

      // Random batches, mostly short, a few full or overflowing.
      while (random_words < RANDOM_JOBS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         roll    = $urandom_range(0, 19);
         if (roll < 12) n = $urandom_range(1, 4);
         else if (roll < 16) n = $urandom_range(5, 8);
         else if (roll < 19) n = $urandom_range(9, JOB_SLOTS);
         else n = $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 4);
         send_batch(n, $urandom_range(0, 2) == 0);
      end
      req_valid <= 1'b0;

      // Let the watcher note the final word before the drain check.
      @(posedge clock);

      // Drain, then keep watching for stray words before the final check.
      while (sb.schedule_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      if (sb.mismatches == 0 && sb.schedule_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: fcfs_schedule_timing.f
design/fst_pkg.sv
design/fst_ctrl.sv
design/fst_datapath.sv
design/fcfs_schedule_timing.sv
sim/tb_fcfs_schedule_timing.sv
